// File: hw/rtl/offset_to_line_table_assert.svh
// ============================================================================
// offset_to_line_table_assert.svh
// Assertion macros used by the offset-to-line table checker.
// ============================================================================
`ifndef OFFSET_TO_LINE_TABLE_ASSERT_SVH
`define OFFSET_TO_LINE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define OLT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define OLT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/olt_pkg.sv
// ============================================================================
// olt_pkg
// Shared sizes, codes and control types of the offset-to-line table.
// ============================================================================
package olt_pkg;

  localparam int MAX_LINES   = 1024;
  localparam int OFFSET_BITS = 16;
  localparam int SRC_W       = 16;
  localparam int LINE_W      = 11;
  localparam int IDX_W       = $clog2(MAX_LINES);
  localparam int CNT_W       = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISS      = 2'd1,
    ST_FULL      = 2'd2,
    ST_LINE_ZERO = 2'd3
  } status_t;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_LOOKUP = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INCR,
    S_SEARCH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    append;
    logic    rd_entry;
    logic    incr;
    logic    search_init;
    logic    search_step;
    logic    set_res;
    status_t res_code;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic lookup;
    logic line_zero;
    logic bytes_full;
    logic line_above;
    logic table_full;
    logic count_zero;
    logic search_done;
    logic out_busy;
  } dp_status_t;

endpackage

// File: hw/rtl/olt_if.sv
// ============================================================================
// olt_if
// Valid/ready channels of the offset-to-line table: request and response.
// ============================================================================
interface olt_req_if
  import olt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [SRC_W-1:0]       source_line;
  logic [OFFSET_BITS-1:0] lookup_offset;

  modport source (output valid, command, source_line, lookup_offset, input ready);
  modport sink   (input valid, command, source_line, lookup_offset, output ready);
endinterface

interface olt_rsp_if
  import olt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_number;
  logic [1:0]        status;

  modport source (output valid, line_number, status, input ready);
  modport sink   (input valid, line_number, status, output ready);
endinterface

// File: hw/rtl/offset_to_line_table.sv
// ============================================================================
// offset_to_line_table
// Byte-offset to source-line table with append/increment and lower-bound lookup.
// ============================================================================
// Usage:
//   req carries one word at a time: command 0 records the source line of the
//   next emitted byte, command 1 asks which line covers lookup_offset.
//   rsp returns exactly one word per request: line_number (lookups only) and
//   status (ok, offset not covered, table or byte counter full, line zero).
//   One request is in flight at a time; req.ready is high only while idle.
//   From accept, a refused or appending record passes through dispatch to the
//   finish step; a record that bumps an existing entry adds an increment step
//   (memory read, then write back), and a lookup of a non-empty table adds up
//   to 11 probes of the binary search (one registered memory read per probe).
//   A new request is accepted only after the previous word is loaded into the
//   output register, so requests do not overlap.
//   The response sits in an output register, so the next request is taken
//   while an earlier word waits for rsp.ready; a second finished word holds
//   in the finish step until the register frees up.
//   Reset (rst, synchronous) empties the table and clears the byte counter;
//   table contents are not cleared and are only read below the entry count.
// ============================================================================
module offset_to_line_table
  import olt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  olt_req_if.sink   req,
  olt_rsp_if.source rsp
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequencer: IDLE -> DISPATCH -> (INCR, SEARCH... or neither) -> FINISH
  olt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Table memory, counters, search window and response register
  olt_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .in_command       (req.command),
    .in_source_line   (req.source_line),
    .in_lookup_offset (req.lookup_offset),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_line_number  (rsp.line_number),
    .out_status       (rsp.status)
  );

endmodule

// File: hw/rtl/olt_ctrl.sv
// ============================================================================
// olt_ctrl
// Sequencer: decodes one word, steps the search, hands off the result.
// ============================================================================
module olt_ctrl
  import olt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.lookup) begin
          if (st.count_zero) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_MISS;
            state_next   = S_FINISH;
          end else begin
            cmd.search_init = 1'b1;
            state_next      = S_SEARCH;
          end
        end else if (st.line_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_LINE_ZERO;
          state_next   = S_FINISH;
        end else if (st.bytes_full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FULL;
          state_next   = S_FINISH;
        end else if (st.line_above) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = st.table_full ? ST_FULL : ST_OK;
          cmd.append   = !st.table_full;
          state_next   = S_FINISH;
        end else begin
          cmd.rd_entry = 1'b1;
          state_next   = S_INCR;
        end
      end
      S_INCR: begin
        cmd.incr     = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_OK;
        state_next   = S_FINISH;
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (st.search_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/olt_datapath.sv
// ============================================================================
// olt_datapath
// Line-end table memory, counters, lower-bound search and result register.
// ============================================================================
module olt_datapath
  import olt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             st,
  input  logic                   in_command,
  input  logic [SRC_W-1:0]       in_source_line,
  input  logic [OFFSET_BITS-1:0] in_lookup_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LINE_W-1:0]      out_line_number,
  output logic [1:0]             out_status
);

  logic [OFFSET_BITS-1:0] mem [MAX_LINES];

  command_t               cmd_q;
  logic [SRC_W-1:0]       src_line_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [CNT_W-1:0]       entry_count;
  logic [OFFSET_BITS-1:0] emitted_bytes;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi;
  logic [CNT_W-1:0]       mid;
  logic [OFFSET_BITS-1:0] rdata;
  logic [LINE_W-1:0]      res_line;
  status_t                res_status;
  status_t                out_status_q;

  logic [SRC_W-1:0]       line_m1;
  logic [IDX_W-1:0]       entry_idx;
  logic                   ge;
  logic [CNT_W-1:0]       lo_n;
  logic [CNT_W-1:0]       hi_n;
  logic [CNT_W:0]         mid_sum;
  logic [CNT_W-1:0]       mid_n;
  logic [CNT_W-1:0]       init_mid;
  logic                   search_done;
  logic                   rd_en;
  logic [IDX_W-1:0]       raddr;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [OFFSET_BITS-1:0] wdata;

  // Decode of the held word
  assign line_m1   = src_line_q - SRC_W'(1);
  assign entry_idx = line_m1[IDX_W-1:0];

  // One probe: compare the returned entry, narrow [lo, hi), pick next midpoint
  assign ge          = (rdata >= offset_q);
  assign lo_n        = ge ? lo : (mid + CNT_W'(1));
  assign hi_n        = ge ? mid : hi;
  assign mid_sum     = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n       = mid_sum[CNT_W:1];
  assign init_mid    = entry_count >> 1;
  assign search_done = (lo_n >= hi_n);

  always_comb begin
    if (cmd.search_init) begin
      raddr = init_mid[IDX_W-1:0];
    end else if (cmd.search_step) begin
      raddr = mid_n[IDX_W-1:0];
    end else begin
      raddr = entry_idx;
    end
  end

  assign rd_en = cmd.rd_entry || cmd.search_init || (cmd.search_step && !search_done);
  assign we    = cmd.append || cmd.incr;
  assign waddr = cmd.append ? entry_count[IDX_W-1:0] : entry_idx;
  assign wdata = cmd.append ? emitted_bytes : (rdata + OFFSET_BITS'(1));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q      <= command_t'(in_command);
      src_line_q <= in_source_line;
      offset_q   <= in_lookup_offset;
    end
    if (cmd.search_init) begin
      lo  <= '0;
      hi  <= entry_count;
      mid <= init_mid;
    end else if (cmd.search_step) begin
      lo  <= lo_n;
      hi  <= hi_n;
      mid <= mid_n;
    end
    if (cmd.set_res) begin
      res_line   <= '0;
      res_status <= cmd.res_code;
    end else if (cmd.search_step && search_done) begin
      if (lo_n < entry_count) begin
        res_line   <= LINE_W'(lo_n + CNT_W'(1));
        res_status <= ST_OK;
      end else begin
        res_line   <= '0;
        res_status <= ST_MISS;
      end
    end
    if (cmd.load_out) begin
      out_line_number <= res_line;
      out_status_q    <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      emitted_bytes <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.append) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (cmd.append || cmd.incr) begin
        emitted_bytes <= emitted_bytes + OFFSET_BITS'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_status = out_status_q;

  assign st.lookup      = (cmd_q == CMD_LOOKUP);
  assign st.line_zero   = (src_line_q == '0);
  assign st.bytes_full  = (emitted_bytes == '1);
  assign st.line_above  = (src_line_q > SRC_W'(entry_count));
  assign st.table_full  = (entry_count == CNT_W'(MAX_LINES));
  assign st.count_zero  = (entry_count == '0);
  assign st.search_done = search_done;
  assign st.out_busy    = out_valid && !out_ready;

endmodule

// File: hw/rtl/olt_checker.sv
// ============================================================================
// olt_checker
// Port-level checks of the offset-to-line table, bound to the top level.
// ============================================================================
`include "offset_to_line_table_assert.svh"

module olt_checker
  import olt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [LINE_W-1:0] rsp_line_number,
  input logic [1:0]        rsp_status
);

  // One word at a time: ready drops right after an accept
  `OLT_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "accepted while busy")

  // Only a successful lookup reports a nonzero line
  `OLT_ASSERT_IMP(a_line_zero_on_error, rsp_valid && (rsp_status != ST_OK), rsp_line_number == '0, "line on error status")

  `OLT_ASSERT_IMP(a_line_in_range, rsp_valid, rsp_line_number <= LINE_W'(MAX_LINES), "line above table size")

  `OLT_ASSERT_NXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

  `OLT_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_line_number) && $stable(rsp_status), "response changed while stalled")

endmodule

bind offset_to_line_table olt_checker u_olt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_line_number (rsp.line_number),
  .rsp_status      (rsp.status)
);
